### design/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants for the tensor transpose scatter block
// Register indexes, field widths, reset values and the stride bundle passed
// from the stride unit to the top level.
// ----------------------------------------------------------------------------
package tts_pkg;

   localparam int AXES           = 4;
   localparam int MAX_RANK       = 4;
   localparam int DEF_DATA_WIDTH = 32;
   localparam int DEF_MAX_DIM    = 4096;
   localparam int DEST_W         = 48;
   localparam int RANK_W         = 3;
   localparam int CFG_DIM_W      = 13;
   localparam int PERM_W         = 8;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 13;
   localparam int FIFO_DEPTH     = 8;

   localparam logic [RANK_W-1:0]    RANK_RST    = 3'd2;
   localparam logic [CFG_DIM_W-1:0] DIM_RST     = 13'd1;
   localparam logic [PERM_W-1:0]    PERM_RST    = 8'd27;
   localparam logic                 REVERSE_RST = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RANK    = 3'd0,
      CSR_DIM0    = 3'd1,
      CSR_DIM1    = 3'd2,
      CSR_DIM2    = 3'd3,
      CSR_DIM3    = 3'd4,
      CSR_PERM    = 3'd5,
      CSR_REVERSE = 3'd6
   } csr_index_type;

   // per output axis k: source input axis, used flag, output stride
   typedef struct packed {
      logic [AXES-1:0][1:0]        perm;
      logic [AXES-1:0]             used;
      logic                        bad;
      logic [AXES-1:0][DEST_W-1:0] stride;
   } stride_info_type;

endpackage

### design/tts_stride.sv
// ----------------------------------------------------------------------------
// tts_stride: permutation decode and output stride products
// Registered chain that turns the configuration into per-output-axis source
// axes and strides: decode registers, then os1_ff, then os0_ff.
// ----------------------------------------------------------------------------
module tts_stride #(
   parameter int EDIM_W = 13
) (
   input  logic                                    clock,
   input  logic [tts_pkg::RANK_W-1:0]              erank,
   input  logic [tts_pkg::AXES-1:0][EDIM_W-1:0]    edim,
   input  logic [tts_pkg::PERM_W-1:0]              perm_code,
   input  logic                                    use_reverse,
   output tts_pkg::stride_info_type                info
);
   import tts_pkg::*;

   localparam int OS1_W = 2 * EDIM_W;
   localparam int OS0_W = 3 * EDIM_W;

   logic [AXES-1:0][1:0]        perm_in, perm_ff;
   logic [AXES-1:0]             used_in, used_ff;
   logic [AXES-1:0]             present;
   logic                        bad_in, bad_ff;
   logic [AXES-1:0][EDIM_W-1:0] pd_in, pd_ff;
   logic [OS1_W-1:0]            os1_ff;
   logic [OS0_W-1:0]            os0_full;
   logic [DEST_W-1:0]           os0_ff;

   always_comb begin
      present = '0;
      for (int k = 0; k < AXES; k++) begin
         used_in[k] = k < int'(erank);
         if (use_reverse) begin
            perm_in[k] = 2'(int'(erank) - 1 - k);
         end else begin
            perm_in[k] = perm_code[2*k +: 2];
         end
      end
      for (int k = 0; k < AXES; k++) begin
         if (used_in[k] && (int'(perm_in[k]) < int'(erank))) begin
            present[perm_in[k]] = 1'b1;
         end
      end
      bad_in = |(used_in & ~present);
      for (int k = 0; k < AXES; k++) begin
         pd_in[k] = used_in[k] ? edim[perm_in[k]] : EDIM_W'(1);
      end
   end

   assign os0_full = OS0_W'(pd_ff[1]) * OS0_W'(os1_ff);

   always_ff @(posedge clock) begin
      perm_ff <= perm_in;
      used_ff <= used_in;
      bad_ff  <= bad_in;
      pd_ff   <= pd_in;
      os1_ff  <= OS1_W'(pd_ff[2]) * OS1_W'(pd_ff[3]);
      os0_ff  <= DEST_W'(os0_full);
   end

   always_comb begin
      info.perm      = perm_ff;
      info.used      = used_ff;
      info.bad       = bad_ff;
      info.stride[3] = DEST_W'(1);
      info.stride[2] = DEST_W'(pd_ff[3]);
      info.stride[1] = DEST_W'(os1_ff);
      info.stride[0] = os0_ff;
   end

endmodule

### design/tts_fifo.sv
// ----------------------------------------------------------------------------
// tts_fifo: result queue
// Small register queue between the compute pipeline and the result port.
// ----------------------------------------------------------------------------
module tts_fifo #(
   parameter int WIDTH = 82,
   parameter int DEPTH = tts_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);
   import tts_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             rd_fire;

   assign rd_valid = count_ff != '0;
   assign rd_fire  = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (rd_fire) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({wr_en, rd_fire})
         2'b10:   count_in = count_ff + (AW+1)'(1);
         2'b01:   count_in = count_ff - (AW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### design/tensor_transpose_scatter.sv
// ----------------------------------------------------------------------------
// tensor_transpose_scatter: streaming N-D tensor transpose index generator
// Passes tensor elements through with their flat position in the permuted
// tensor, marks the last element and flags an invalid permutation.
// ----------------------------------------------------------------------------
// Elements enter one per item in row-major input order and leave in the same
// order, one result per element, at a sustained rate of one item per clock
// while the result port takes results. The clock that accepts an element
// captures its coordinate; then come registered stages for axis selection,
// alignment with the stride chain, the coordinate-by-stride multipliers, and
// the adder tree and queue write. An eight-entry result queue with credit
// counting keeps the input side taking items while results wait; req_tready
// drops only when eight items are queued or in flight. A register write
// applies to items accepted on a later clock; the user must make it only
// while no item is in flight, which the block itself does not enforce, as
// the pipeline and the stride chain read the registers while items pass. The
// coordinate counter keeps its position across register writes, so writes
// are best made between tensors.
// ----------------------------------------------------------------------------
module tensor_transpose_scatter #(
   parameter int DATA_WIDTH = tts_pkg::DEF_DATA_WIDTH,
   parameter int MAX_DIM    = tts_pkg::DEF_MAX_DIM
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // element_value
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_value, dest_index
   output logic [((DATA_WIDTH+tts_pkg::DEST_W+7)/8)*8-1:0] rsp_tdata,
   output logic                                rsp_tlast,
   // perm_error
   output logic                                rsp_tuser,
   // configuration writes
   input  logic                                csr_we,
   input  logic [tts_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [tts_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tts_pkg::*;

   localparam int RSP_W   = ((DATA_WIDTH + DEST_W + 7) / 8) * 8;
   localparam int CW      = $clog2(MAX_DIM);       // coordinate width
   localparam int EDIM_W  = $clog2(MAX_DIM + 1);   // clamped extent width
   localparam int CMP_W   = EDIM_W + 1;
   localparam int PROD_W  = CW + DEST_W;
   localparam int ENTRY_W = DATA_WIDTH + DEST_W + 2;
   localparam int CNT_W   = $clog2(FIFO_DEPTH) + 1;
   localparam int STAGES  = 5;

   // configuration registers
   logic [RANK_W-1:0]                rank_ff;
   logic [AXES-1:0][CFG_DIM_W-1:0]   dim_ff;
   logic [PERM_W-1:0]                perm_code_ff;
   logic                             use_reverse_ff;

   // effective configuration
   logic [RANK_W-1:0]                erank;
   logic [AXES-1:0][EDIM_W-1:0]      edim;
   stride_info_type                  info;

   // coordinate counter
   logic [AXES-1:0][CW-1:0]          coord_ff, coord_in;
   logic [AXES-1:0]                  axis_used, can_inc;
   logic                             last_w;
   logic                             carry;

   // handshake and credits
   logic                             req_fire, rsp_fire;
   logic [CNT_W-1:0]                 credit_ff, credit_in;

   // compute pipeline, stage 0 is the capture stage
   logic [STAGES-1:0]                    valid_ff;
   logic [STAGES-1:0][DATA_WIDTH-1:0]    value_ff;
   logic [STAGES-1:0]                    last_ff;
   logic [AXES-1:0][CW-1:0]              coord_a_ff;
   logic [AXES-1:0][CW-1:0]              mc_b_ff, mc_c_ff;
   logic [AXES-1:0][PROD_W-1:0]          prod_w;
   logic [AXES-1:0][DEST_W-1:0]          prod_d_ff;
   logic [1:0][DEST_W-1:0]               sum_e_ff;
   logic [DEST_W-1:0]                    dest_w;

   logic [ENTRY_W-1:0]                   wr_entry, rd_entry;

   // ---- configuration port ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff        <= RANK_RST;
         dim_ff         <= {AXES{DIM_RST}};
         perm_code_ff   <= PERM_RST;
         use_reverse_ff <= REVERSE_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_RANK:    rank_ff        <= csr_wdata[RANK_W-1:0];
            CSR_DIM0:    dim_ff[0]      <= csr_wdata[CFG_DIM_W-1:0];
            CSR_DIM1:    dim_ff[1]      <= csr_wdata[CFG_DIM_W-1:0];
            CSR_DIM2:    dim_ff[2]      <= csr_wdata[CFG_DIM_W-1:0];
            CSR_DIM3:    dim_ff[3]      <= csr_wdata[CFG_DIM_W-1:0];
            CSR_PERM:    perm_code_ff   <= csr_wdata[PERM_W-1:0];
            CSR_REVERSE: use_reverse_ff <= csr_wdata[0];
            default:     ;
         endcase
      end
   end

   // rank clamps to 1..MAX_RANK, extents to 1..MAX_DIM
   always_comb begin
      if (rank_ff == '0) begin
         erank = RANK_W'(1);
      end else if (int'(rank_ff) > MAX_RANK) begin
         erank = RANK_W'(MAX_RANK);
      end else begin
         erank = rank_ff;
      end
      for (int k = 0; k < AXES; k++) begin
         if (dim_ff[k] == '0) begin
            edim[k] = EDIM_W'(1);
         end else if (int'(dim_ff[k]) > MAX_DIM) begin
            edim[k] = EDIM_W'(MAX_DIM);
         end else begin
            edim[k] = EDIM_W'(dim_ff[k]);
         end
      end
   end

   tts_stride #(
      .EDIM_W (EDIM_W)
   ) u_stride (
      .clock       (clock),
      .erank       (erank),
      .edim        (edim),
      .perm_code   (perm_code_ff),
      .use_reverse (use_reverse_ff),
      .info        (info)
   );

   // ---- coordinate counter ----
   // Innermost used axis increments; an axis at or past its extent minus one
   // wraps and carries. Last element when no used axis can increment.
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         axis_used[k] = k < int'(erank);
         can_inc[k]   = (CMP_W'(coord_ff[k]) + CMP_W'(1)) < CMP_W'(edim[k]);
      end
      last_w   = ~|(axis_used & can_inc);
      coord_in = coord_ff;
      carry    = 1'b1;
      for (int k = AXES - 1; k >= 0; k--) begin
         if (axis_used[k] && carry) begin
            if (can_inc[k]) begin
               coord_in[k] = coord_ff[k] + CW'(1);
               carry       = 1'b0;
            end else begin
               coord_in[k] = '0;
            end
         end
      end
      if (last_w) begin
         coord_in = '0;
      end
   end

   // ---- credits: items in flight plus items queued ----
   assign req_tready = credit_ff != CNT_W'(FIFO_DEPTH);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_comb begin
      case ({req_fire, rsp_fire})
         2'b10:   credit_in = credit_ff + CNT_W'(1);
         2'b01:   credit_in = credit_ff - CNT_W'(1);
         default: credit_in = credit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_ff  <= '0;
         credit_ff <= '0;
         valid_ff  <= '0;
      end else begin
         if (req_fire) begin
            coord_ff <= coord_in;
         end
         credit_ff <= credit_in;
         valid_ff  <= {valid_ff[STAGES-2:0], req_fire};
      end
   end

   // ---- dot product pipeline ----
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         prod_w[k] = PROD_W'(mc_c_ff[k]) * PROD_W'(info.stride[k]);
      end
   end

   always_ff @(posedge clock) begin
      value_ff[0]  <= req_tdata[DATA_WIDTH-1:0];
      last_ff[0]   <= last_w;
      coord_a_ff   <= coord_ff;
      for (int i = 1; i < STAGES; i++) begin
         value_ff[i] <= value_ff[i-1];
         last_ff[i]  <= last_ff[i-1];
      end
      // output axis k reads input coordinate perm[k]
      for (int k = 0; k < AXES; k++) begin
         mc_b_ff[k]   <= info.used[k] ? coord_a_ff[info.perm[k]] : '0;
         prod_d_ff[k] <= prod_w[k][DEST_W-1:0];
      end
      mc_c_ff     <= mc_b_ff;
      sum_e_ff[0] <= prod_d_ff[0] + prod_d_ff[1];
      sum_e_ff[1] <= prod_d_ff[2] + prod_d_ff[3];
   end

   assign dest_w   = info.bad ? '0 : sum_e_ff[0] + sum_e_ff[1];
   assign wr_entry = {info.bad, last_ff[STAGES-1], dest_w, value_ff[STAGES-1]};

   tts_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (valid_ff[STAGES-1]),
      .wr_data  (wr_entry),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (rd_entry)
   );

   assign rsp_tdata = RSP_W'(rd_entry[DATA_WIDTH+DEST_W-1:0]);
   assign rsp_tlast = rd_entry[DATA_WIDTH+DEST_W];
   assign rsp_tuser = rd_entry[DATA_WIDTH+DEST_W+1];

   // ---- assertions ----
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CNT_W'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> credit_ff != '0)
      else $error("result offered with no item outstanding");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && last_w) |=> coord_ff == '0)
      else $error("counter did not wrap after last element");

   a_bad_zero_dest: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tdata[DATA_WIDTH +: DEST_W] == '0)
      else $error("nonzero index with permutation error");

endmodule
